### hdl/csip_pkg.sv
// Package: shared types and codes of the circular sorted insert position block.
package csip_pkg;

    localparam int VALUE_W = 32;
    localparam int POS_W   = 6;
    localparam int OP_W    = 2;
    localparam int STAT_W  = 2;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_QUERY  = 2'd2
    } opcode_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_EMPTY    = 2'd1,
        STAT_NO_PLACE = 2'd2,
        STAT_FULL     = 2'd3
    } status_t;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic do_clear;
        logic do_append;
        logic do_quick;
        logic do_start;
        logic do_walk;
        logic do_walk_done;
    } csip_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic quick_done;
        logic walk_hit;
        logic walk_end;
    } csip_stat_t;

endpackage

### hdl/csip_if.sv
// Interfaces: input word channel and result word channel.
interface csip_in_if;
    import csip_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [OP_W-1:0]           opcode;
    logic signed [VALUE_W-1:0] item_value;

    modport source (output valid, output opcode, output item_value, input ready);
    modport sink   (input valid, input opcode, input item_value, output ready);
endinterface

interface csip_out_if;
    import csip_pkg::*;

    logic              valid;
    logic              ready;
    logic [POS_W-1:0]  position;
    logic [STAT_W-1:0] status;

    modport source (output valid, output position, output status, input ready);
    modport sink   (input valid, input position, input status, output ready);
endinterface

### hdl/csip_ctrl.sv
// Controller: accepts words, sequences the store walk and owns the result valid flag.
module csip_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [1:0]           in_opcode,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output csip_pkg::csip_cmd_t  cmd,
    input  csip_pkg::csip_stat_t stat
);
    import csip_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;
    logic   result_set;

    assign in_ready  = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (in_opcode == OP_QUERY) && !stat.quick_done)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (stat.walk_hit || stat.walk_end)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd        = '0;
        result_set = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_opcode)
                        OP_CLEAR:
                        begin
                            cmd.do_clear = 1'b1;
                        end
                        OP_APPEND:
                        begin
                            cmd.do_append = 1'b1;
                            result_set    = 1'b1;
                        end
                        OP_QUERY:
                        begin
                            if (stat.quick_done)
                            begin
                                cmd.do_quick = 1'b1;
                                result_set   = 1'b1;
                            end
                            else
                            begin
                                cmd.do_start = 1'b1;
                            end
                        end
                        default:
                        begin
                            // unused opcode: drop the word
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                cmd.do_walk = 1'b1;
                if (stat.walk_hit || stat.walk_end)
                begin
                    cmd.do_walk_done = 1'b1;
                    result_set       = 1'b1;
                end
            end
        endcase
    end

    assign out_valid_next = result_set || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### hdl/csip_datapath.sv
// Datapath: value store, extreme trackers, walk comparators and result register.
module csip_datapath #(
    parameter int STORE_DEPTH = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic                                 cfg_wdata,
    input  logic signed [csip_pkg::VALUE_W-1:0]  in_value,
    input  csip_pkg::csip_cmd_t                  cmd,
    output csip_pkg::csip_stat_t                 stat,
    output logic [csip_pkg::POS_W-1:0]           position,
    output logic [csip_pkg::STAT_W-1:0]          status
);
    import csip_pkg::*;

    localparam int IDX_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CNT_W = $clog2(STORE_DEPTH + 1);

    logic signed [VALUE_W-1:0] mem [STORE_DEPTH];

    logic                      desc_reg;
    logic [CNT_W-1:0]          count_reg;
    logic signed [VALUE_W-1:0] largest_reg;
    logic signed [VALUE_W-1:0] smallest_reg;
    logic [IDX_W-1:0]          largest_idx_reg;
    logic [IDX_W-1:0]          smallest_idx_reg;
    logic signed [VALUE_W-1:0] first_reg;
    logic signed [VALUE_W-1:0] last_reg;
    logic signed [VALUE_W-1:0] value_reg;
    logic [IDX_W-1:0]          rd_addr_reg;
    logic [IDX_W-1:0]          data_idx_reg;
    logic                      data_ok_reg;
    logic signed [VALUE_W-1:0] rd_data_reg;
    logic signed [VALUE_W-1:0] prev_reg;
    logic [POS_W-1:0]          position_reg;
    logic [STAT_W-1:0]         status_reg;

    logic [POS_W-1:0]          quick_pos;
    logic [STAT_W-1:0]         quick_status;
    logic                      quick_done;
    logic [POS_W-1:0]          append_pos;
    logic [STAT_W-1:0]         append_status;
    logic                      is_full;
    logic                      between;
    logic                      extreme;
    logic                      pair_valid;
    logic                      pair_match;
    logic                      last_pair;
    logic                      walk_hit;
    logic                      walk_end;
    logic [CNT_W-1:0]          count_m1;
    logic [IDX_W-1:0]          extreme_idx;
    logic [IDX_W-1:0]          wr_idx;

    // Fit an index into the 6-bit position field (zero-extend or mask).
    function automatic logic [POS_W-1:0] to_pos(input logic [IDX_W-1:0] idx);
        logic [POS_W+IDX_W-1:0] wide;
        wide = {{POS_W{1'b0}}, idx};
        return wide[POS_W-1:0];
    endfunction

    assign is_full  = (count_reg >= CNT_W'(STORE_DEPTH));
    assign wr_idx   = count_reg[IDX_W-1:0];
    assign count_m1 = count_reg - CNT_W'(1);

    // Append result
    always_comb
    begin
        if (is_full)
        begin
            append_pos    = '0;
            append_status = STAT_FULL;
        end
        else
        begin
            append_pos    = to_pos(wr_idx);
            append_status = STAT_OK;
        end
    end

    // Query checks that need no walk: empty, wrap gap, new extreme, single entry.
    assign between = desc_reg ? ((in_value > first_reg) && (in_value < last_reg))
                              : ((in_value < first_reg) && (in_value > last_reg));
    assign extreme     = (in_value > largest_reg) || (in_value < smallest_reg);
    assign extreme_idx = desc_reg ? largest_idx_reg : smallest_idx_reg;

    always_comb
    begin
        quick_done   = 1'b1;
        quick_pos    = '0;
        quick_status = STAT_OK;
        priority if (count_reg == '0)
        begin
            quick_status = STAT_EMPTY;
        end
        else if (between)
        begin
            quick_status = STAT_OK;
        end
        else if (extreme)
        begin
            quick_pos = to_pos(extreme_idx);
        end
        else if (count_reg == CNT_W'(1))
        begin
            quick_status = STAT_NO_PLACE;
        end
        else
        begin
            quick_done = 1'b0;
        end
    end

    // Walk: prev_reg holds entry data_idx-1, rd_data_reg entry data_idx.
    // The controller only looks at hit and end while it walks.
    assign pair_valid = data_ok_reg && (data_idx_reg != '0);
    assign pair_match = desc_reg ? ((prev_reg >= value_reg) && (rd_data_reg <= value_reg))
                                 : ((prev_reg <= value_reg) && (rd_data_reg >= value_reg));
    assign last_pair  = ({1'b0, data_idx_reg} == {1'b0, count_m1[IDX_W-1:0]})
                        && (count_m1 < CNT_W'(STORE_DEPTH));
    assign walk_hit   = pair_valid && pair_match;
    assign walk_end   = pair_valid && !pair_match && last_pair;

    assign stat = {quick_done, walk_hit, walk_end};

    // Store array: write on append, registered read during the walk.
    always_ff @(posedge clk)
    begin
        if (cmd.do_append && !is_full)
        begin
            mem[wr_idx] <= in_value;
        end
        if (cmd.do_walk)
        begin
            rd_data_reg <= mem[rd_addr_reg];
            prev_reg    <= rd_data_reg;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.do_append && !is_full)
        begin
            last_reg <= in_value;
            if (count_reg == '0)
            begin
                first_reg <= in_value;
            end
        end
        if (cmd.do_start)
        begin
            value_reg <= in_value;
        end
        if (cmd.do_append)
        begin
            position_reg <= append_pos;
            status_reg   <= append_status;
        end
        else if (cmd.do_quick)
        begin
            position_reg <= quick_pos;
            status_reg   <= quick_status;
        end
        else if (cmd.do_walk_done)
        begin
            position_reg <= walk_hit ? to_pos(data_idx_reg) : '0;
            status_reg   <= walk_hit ? STAT_OK : STAT_NO_PLACE;
        end
    end

    // Control state: count, extremes, walk counters, mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            desc_reg         <= 1'b1;
            count_reg        <= '0;
            largest_reg      <= '0;
            smallest_reg     <= '0;
            largest_idx_reg  <= '0;
            smallest_idx_reg <= '0;
            rd_addr_reg      <= '0;
            data_idx_reg     <= '0;
            data_ok_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                desc_reg <= cfg_wdata;
            end
            if (cmd.do_clear)
            begin
                count_reg        <= '0;
                largest_reg      <= '0;
                smallest_reg     <= '0;
                largest_idx_reg  <= '0;
                smallest_idx_reg <= '0;
            end
            else if (cmd.do_append && !is_full)
            begin
                count_reg <= count_reg + CNT_W'(1);
                if (count_reg == '0)
                begin
                    largest_reg      <= in_value;
                    smallest_reg     <= in_value;
                    largest_idx_reg  <= '0;
                    smallest_idx_reg <= '0;
                end
                else
                begin
                    if (in_value > largest_reg)
                    begin
                        largest_reg     <= in_value;
                        largest_idx_reg <= wr_idx;
                    end
                    if (in_value < smallest_reg)
                    begin
                        smallest_reg     <= in_value;
                        smallest_idx_reg <= wr_idx;
                    end
                end
            end
            if (cmd.do_start)
            begin
                rd_addr_reg <= '0;
                data_ok_reg <= 1'b0;
            end
            else if (cmd.do_walk)
            begin
                rd_addr_reg  <= rd_addr_reg + IDX_W'(1);
                data_idx_reg <= rd_addr_reg;
                data_ok_reg  <= 1'b1;
            end
        end
    end

    assign position = position_reg;
    assign status   = status_reg;

endmodule

### hdl/circular_sorted_insert_position.sv
// Top level: insertion index finder over a rotated sorted store of signed values.
//
// Usage:
//   in_ch carries one word per handshake: opcode (0 clear, 1 append, 2 query)
//   and a signed 32-bit item_value. out_ch returns one word of position and
//   status for every append and query; clear and the unused opcode return none.
//   cfg_we/cfg_wdata write the descending_order mode bit (reset value 1);
//   write it only while the block is idle.
// Result path:
//   The result word of an append appears the cycle after acceptance, as does
//   that of a query settled without a walk (empty store, gap between last and
//   first entries, new extreme, single entry). Otherwise the controller walks
//   the store one entry per cycle through its single registered read port
//   until a neighbour pair holds the value or the last pair has been checked.
// Reset:
//   rst_n clears the entry count, the extreme trackers and the mode bit to
//   descending. Store contents are not cleared; the count guards every read.
// Back-pressure:
//   The result word holds in its output register while out_ch.ready is low.
//   A new word is taken once the controller is idle and the output register
//   is empty or being drained in the same cycle.
module circular_sorted_insert_position #(
    parameter int STORE_DEPTH = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic             cfg_wdata,
    csip_in_if.sink          in_ch,
    csip_out_if.source       out_ch
);
    import csip_pkg::*;

    csip_cmd_t  cmd;
    csip_stat_t stat;

    // Sequence accepts, walk steps and the result valid flag.
    csip_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_opcode (in_ch.opcode),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    // Hold the store, track extremes and compare neighbor pairs.
    csip_datapath #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_value  (in_ch.item_value),
        .cmd       (cmd),
        .stat      (stat),
        .position  (out_ch.position),
        .status    (out_ch.status)
    );

endmodule
